// ----- rtl/gpco_pkg.sv -----
// Shared constants and control types for the greedy point chain ordering block.
`default_nettype none

package gpco_pkg;

  localparam int MAX_CONES   = 64;
  localparam int RESULT_CAP  = 64;
  localparam int IDX_W       = $clog2(MAX_CONES);
  localparam int CNT_W       = $clog2(MAX_CONES + 1);
  localparam int KCNT_W      = $clog2(RESULT_CAP + 1);
  localparam int COORD_W     = 16;
  localparam int OUT_IDX_W   = 6;
  localparam int ENTRY_W     = 3 * COORD_W;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = SQ_W + 1;

  typedef enum logic [1:0] {
    MODE_RANGE,
    MODE_DEDUP,
    MODE_NN
  } scan_mode_t;

  typedef struct packed {
    logic       scan_start;
    scan_mode_t mode;
    logic       take_best;
    logic       emit;
    logic       emit_last;
    logic       clear_set;
  } gpco_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic append_ok;
    logic out_free;
  } gpco_stat_t;

endpackage

`default_nettype wire

// ----- rtl/greedy_point_chain_order.sv -----
// Top level of the greedy point chain ordering block.
// Loading takes one item per cycle; the item carrying tlast starts ordering and the input
// stalls until the last result of the chain is in the output register. The start search and
// the duplicate removal each scan the n stored points, and each result costs one
// nearest-point scan; every scan reads the point store through its single read port.
// Reset (rst, synchronous, active high) empties the set and sets max_gap to 1280.
`default_nettype none

module greedy_point_chain_order (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // point_x[15:0], point_y[31:16], origin_range[47:32]
  input  wire logic        s_axis_tlast,  // in_last
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // out_x[15:0], out_y[31:16], out_index[37:32], zero
  output logic             m_axis_tlast,  // out_last
  // Configuration: max_gap, unsigned Q8.8.
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import gpco_pkg::*;

  gpco_cmd_t  cmd;
  gpco_stat_t stat;

  logic signed [COORD_W-1:0] out_x, out_y;
  logic        [OUT_IDX_W-1:0] out_index;

  // The controller sequences the phases: load, start search, duplicate removal,
  // then alternating nearest-point scans and emissions until the chain ends.
  gpco_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the points, runs the scan pipeline and owns the output register,
  // so a result waiting for the consumer does not block the next set from loading.
  gpco_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .point_x      (s_axis_tdata[15:0]),
    .point_y      (s_axis_tdata[31:16]),
    .origin_range (s_axis_tdata[47:32]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_index    (out_index),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_index, out_y, out_x};

endmodule

`default_nettype wire

// ----- rtl/gpco_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module gpco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gpco_ctrl.sv -----
// Controller state machine that sequences loading, scans and emission.
`default_nettype none

module gpco_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  input  wire gpco_pkg::gpco_stat_t stat,
  output gpco_pkg::gpco_cmd_t       cmd
);
  import gpco_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RANGE,
    S_DEDUP,
    S_NN,
    S_EMIT
  } state_t;

  state_t    state, state_next;
  gpco_cmd_t cmd_next;
  logic      more, more_next;

  // The clear pulse resets the fill count, so no item is taken in that cycle.
  assign in_ready = (state == S_LOAD) && !cmd.clear_set;

  always_comb begin
    state_next = state;
    cmd_next   = '0;
    more_next  = more;
    case (state)
      S_LOAD: begin
        if (in_valid && in_ready && in_last) begin
          cmd_next.scan_start = 1'b1;
          cmd_next.mode       = MODE_RANGE;
          state_next          = S_RANGE;
        end
      end
      S_RANGE: begin
        if (stat.scan_done) begin
          cmd_next.take_best  = 1'b1;
          cmd_next.scan_start = 1'b1;
          cmd_next.mode       = MODE_DEDUP;
          state_next          = S_DEDUP;
        end
      end
      S_DEDUP: begin
        if (stat.scan_done) begin
          cmd_next.scan_start = 1'b1;
          cmd_next.mode       = MODE_NN;
          state_next          = S_NN;
        end
      end
      S_NN: begin
        if (stat.scan_done) begin
          more_next  = stat.append_ok;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd_next.emit      = 1'b1;
          cmd_next.emit_last = !more;
          if (more) begin
            cmd_next.take_best  = 1'b1;
            cmd_next.scan_start = 1'b1;
            cmd_next.mode       = MODE_NN;
            state_next          = S_NN;
          end else begin
            cmd_next.clear_set = 1'b1;
            state_next         = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cmd   <= '0;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
      more  <= more_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gpco_dpath.sv -----
// Datapath: point store, used marks, scan pipeline, best tracking and output register.
`default_nettype none

module gpco_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic signed [gpco_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [gpco_pkg::COORD_W-1:0] point_y,
  input  wire logic        [gpco_pkg::COORD_W-1:0] origin_range,
  input  wire logic                                cfg_we,
  input  wire logic        [gpco_pkg::COORD_W-1:0] cfg_wdata,
  input  wire gpco_pkg::gpco_cmd_t                 cmd,
  output gpco_pkg::gpco_stat_t                     stat,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [gpco_pkg::COORD_W-1:0]      out_x,
  output logic signed [gpco_pkg::COORD_W-1:0]      out_y,
  output logic        [gpco_pkg::OUT_IDX_W-1:0]    out_index,
  output logic                                     out_last
);
  import gpco_pkg::*;

  // Configuration and the squared gap limit.
  logic [COORD_W-1:0] max_gap;
  logic [SQ_W-1:0]    limit;

  // Set bookkeeping.
  logic [CNT_W-1:0]     count;
  logic [MAX_CONES-1:0] used;
  logic [KCNT_W-1:0]    kcnt;

  // Store access.
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_data;
  logic               issuing;
  logic [IDX_W-1:0]   rd_addr;
  logic               issue_last;
  scan_mode_t         mode;

  // Chain head and pending result.
  logic [COORD_W-1:0] head_x, head_y;
  logic [COORD_W-1:0] pend_x, pend_y;
  logic [IDX_W-1:0]   pend_idx;

  // Pipeline stage 1 (RAM data valid).
  logic             p1, last1;
  logic [IDX_W-1:0] idx1;
  logic [COORD_W-1:0] x1, y1, r1;

  // Pipeline stage 2.
  logic               p2, last2, v2, eq2;
  logic [IDX_W-1:0]   idx2;
  logic [COORD_W-1:0] x2, y2, r2, ax2, ay2;

  // Pipeline stage 3.
  logic               p3, last3, v3;
  logic [IDX_W-1:0]   idx3;
  logic [COORD_W-1:0] x3, y3, r3;
  logic [SQ_W-1:0]    sqx3, sqy3;

  // Best candidate.
  logic               found;
  logic [DIST_W-1:0]  best_d;
  logic [IDX_W-1:0]   best_idx;
  logic [COORD_W-1:0] best_x, best_y;
  logic               scan_done;

  logic signed [COORD_W:0] dx1, dy1;
  logic [DIST_W-1:0]       metric;
  logic                    better;

  assign wr_en = in_valid && in_ready && (count < CNT_W'(MAX_CONES));
  assign issue_last = (CNT_W'(rd_addr) == CNT_W'(count - CNT_W'(1)));
  assign {r1, y1, x1} = rd_data;

  gpco_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CONES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data ({origin_range, point_y, point_x}),
    .rd_en   (issuing),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    dx1 = $signed({x1[COORD_W-1], x1}) - $signed({head_x[COORD_W-1], head_x});
    dy1 = $signed({y1[COORD_W-1], y1}) - $signed({head_y[COORD_W-1], head_y});
    if (mode == MODE_RANGE) begin
      metric = DIST_W'(r3);
    end else begin
      metric = DIST_W'(sqx3) + DIST_W'(sqy3);
    end
    better = v3 && (!found || (metric < best_d));
  end

  assign stat.scan_done = scan_done;
  assign stat.append_ok = found && (best_d <= DIST_W'(limit)) &&
                          (kcnt < KCNT_W'(RESULT_CAP));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    limit <= SQ_W'(max_gap) * SQ_W'(max_gap);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap   <= COORD_W'(1280);
      count     <= '0;
      used      <= '0;
      kcnt      <= '0;
      issuing   <= 1'b0;
      rd_addr   <= '0;
      mode      <= MODE_RANGE;
      p1        <= 1'b0;
      p2        <= 1'b0;
      p3        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      found     <= 1'b0;
      scan_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap <= cfg_wdata;
      end
      if (cmd.clear_set) begin
        count <= '0;
        kcnt  <= '0;
      end else if (wr_en) begin
        count <= count + CNT_W'(1);
      end

      if (cmd.scan_start) begin
        issuing <= 1'b1;
        rd_addr <= '0;
        mode    <= cmd.mode;
      end else if (issuing) begin
        if (issue_last) begin
          issuing <= 1'b0;
        end else begin
          rd_addr <= rd_addr + IDX_W'(1);
        end
      end

      p1 <= issuing;
      p2 <= p1;
      v2 <= p1 && ((mode != MODE_NN) || !used[idx1]);
      p3 <= p2;
      v3 <= v2;
      scan_done <= p3 && last3;

      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (better) begin
        found <= 1'b1;
      end

      if (cmd.clear_set) begin
        used <= '0;
      end else begin
        if (p2 && (mode == MODE_DEDUP) && eq2) begin
          used[idx2] <= 1'b1;
        end
        if (cmd.take_best) begin
          used[best_idx] <= 1'b1;
        end
      end

      if (cmd.take_best) begin
        kcnt <= kcnt + KCNT_W'(1);
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx1  <= rd_addr;
    last1 <= issue_last;

    idx2  <= idx1;
    last2 <= last1;
    x2    <= x1;
    y2    <= y1;
    r2    <= r1;
    ax2   <= dx1[COORD_W] ? COORD_W'(-dx1) : dx1[COORD_W-1:0];
    ay2   <= dy1[COORD_W] ? COORD_W'(-dy1) : dy1[COORD_W-1:0];
    eq2   <= (x1 == head_x) && (y1 == head_y);

    idx3  <= idx2;
    last3 <= last2;
    x3    <= x2;
    y3    <= y2;
    r3    <= r2;
    sqx3  <= SQ_W'(ax2) * SQ_W'(ax2);
    sqy3  <= SQ_W'(ay2) * SQ_W'(ay2);

    if (better) begin
      best_d   <= metric;
      best_idx <= idx3;
      best_x   <= x3;
      best_y   <= y3;
    end

    if (cmd.take_best) begin
      head_x   <= best_x;
      head_y   <= best_y;
      pend_x   <= best_x;
      pend_y   <= best_y;
      pend_idx <= best_idx;
    end

    if (cmd.emit) begin
      out_x     <= pend_x;
      out_y     <= pend_y;
      out_index <= OUT_IDX_W'(pend_idx);
      out_last  <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gpco_checker.sv -----
// Port-level checker for the greedy point chain ordering block, with its bind.
`default_nettype none

module gpco_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // Ordering starts right after the final item of a set, so input stalls.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after the final item of a set");

  // A new result only appears while the input side is held off.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input was being accepted");

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind greedy_point_chain_order gpco_checker u_gpco_checker (.*);

`default_nettype wire
